/* hdl/wssc_pkg.sv */
// ----------------------------------------------------------------------------
// wssc_pkg
// Shared types, register codes and fixed-point constants of the wind speed
// sensor conditioner.
// ----------------------------------------------------------------------------
package wssc_pkg;

  // apb address width and register indexes (paddr[4:2])
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd0;
  localparam logic [IDX_W-1:0] REG_VOLT_MIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_VOLT_MAX   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_EMA_ALPHA  = 3'd4;

  // configuration field widths
  localparam int unsigned FS_W    = 12;
  localparam int unsigned MV_W    = 13;
  localparam int unsigned SMAX_W  = 14;
  localparam int unsigned ALPHA_W = 16;

  // reset values of the registers
  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 12'd4095;
  localparam logic [MV_W-1:0]    VOLT_MIN_RST   = 13'd400;
  localparam logic [MV_W-1:0]    VOLT_MAX_RST   = 13'd2000;
  localparam logic [SMAX_W-1:0]  SPEED_MAX_RST  = 14'd3240;
  localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST  = 16'd7864;

  typedef struct packed {
    logic [FS_W-1:0]    full_scale;
    logic [MV_W-1:0]    volt_min;
    logic [MV_W-1:0]    volt_max;
    logic [SMAX_W-1:0]  speed_max;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  // datapath widths
  localparam int unsigned U_W     = 20;   // normalized reading, Q0.20
  localparam int unsigned ACC_W   = 37;   // horner accumulator, Q32 volts
  localparam int unsigned PROD_W  = 58;   // accumulator times reading
  localparam int unsigned SPEED_W = 24;   // speed in cm/s, Q8
  localparam int unsigned OUT_W   = 14;

  localparam logic [SPEED_W-1:0] SPEED_SAT = 24'hFFFFFF;
  localparam logic [OUT_W-1:0]   OUT_MAX   = 14'd9999;

  // floor(x / 100) = (x * RECIP_100) >> 29 for x below 2^22
  localparam logic [22:0] RECIP_100 = 23'd5368710;

  // leading quartic coefficient, the others follow in horner order
  localparam logic signed [ACC_W-1:0] POLY_D4 = -37'sd19342813114;

  function automatic logic signed [ACC_W-1:0] poly_coef(input logic [1:0] step);
    logic signed [ACC_W-1:0] c;
    case (step)
      2'd0:    c = 37'sd34877923103;
      2'd1:    c = -37'sd21704589750;
      2'd2:    c = 37'sd19510073356;
      2'd3:    c = 37'sd146645322;
      default: c = '0;
    endcase
    return c;
  endfunction

  // shared restoring divider
  localparam int unsigned DIV_D_W   = 21;
  localparam int unsigned DIV_Q_W   = 24;
  localparam int unsigned DIV_CNT_W = 5;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_D_W-1:0]   rem_init;
    logic [DIV_Q_W-1:0]   low_init;
    logic [DIV_D_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  // back end sequencer
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_UDIV,
    BK_POLY_LO,
    BK_POLY_HI,
    BK_POLY_ADD,
    BK_VOLT,
    BK_SPD_MUL,
    BK_SPD_CHK,
    BK_SPD_DIV,
    BK_MEDIAN,
    BK_EMA_MUL,
    BK_EMA_MAC,
    BK_EMA_SET,
    BK_OUT_SCALE,
    BK_OUT_MUL,
    BK_FINISH
  } back_state_e;

endpackage

/* hdl/wssc_front.sv */
// ----------------------------------------------------------------------------
// wssc_front
// Sums raw samples in groups, checks the group mean against the range 1..full
// scale and pushes each finished group into the queue.
// ----------------------------------------------------------------------------
module wssc_front #(
  parameter int unsigned N        = 32,
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned SUM_W    = 17,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wssc_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ADC_BITS-1:0]  adc_sample_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output logic [SUM_W:0]       push_data_o
);

  localparam int unsigned LIM_W = wssc_pkg::FS_W + $clog2(N) + 1;
  localparam int unsigned CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             last, accept, in_range;
  logic [SUM_W-1:0] total;
  logic [CMP_W-1:0] total_ext, limit;

  // group end stalls only while the queue is full
  assign last       = (count_q == CNT_W'(N - 1));
  assign in_ready_o = !(last && queue_full_i);
  assign accept     = in_valid_i && in_ready_o;

  // running total including the sample on the port
  assign total = sum_q + SUM_W'(adc_sample_i);

  // mean within 1..full scale, tested on the sum
  assign total_ext = CMP_W'(total);
  assign limit     = CMP_W'(cfg_i.full_scale) * CMP_W'(N);
  assign in_range  = (total_ext >= CMP_W'(N)) && (total_ext <= limit);

  assign push_o      = accept && last;
  assign push_data_o = {in_range, total};

  // accumulator next state
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (accept) begin
      if (last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = total;
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

/* hdl/wssc_queue.sv */
// ----------------------------------------------------------------------------
// wssc_queue
// Two-entry queue between the accumulator and the math sequencer.
// ----------------------------------------------------------------------------
module wssc_queue #(
  parameter int unsigned WIDTH = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             nonempty_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign nonempty_o = (fill_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("queue read while empty");

endmodule

/* hdl/wssc_divider.sv */
// ----------------------------------------------------------------------------
// wssc_divider
// Restoring divider, one quotient bit per cycle, shared by the reading
// normalization and the speed scaling.
// ----------------------------------------------------------------------------
module wssc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wssc_pkg::div_req_t req_i,
  output wssc_pkg::div_rsp_t rsp_o
);

  logic [wssc_pkg::DIV_D_W-1:0]   rem_q, dsr_q;
  logic [wssc_pkg::DIV_Q_W-1:0]   low_q, quo_q;
  logic [wssc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [wssc_pkg::DIV_D_W:0]     trial, diff;
  logic                           ge;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_q, low_q[wssc_pkg::DIV_Q_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == wssc_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend shifter and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      low_q <= req_i.low_init;
      dsr_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[wssc_pkg::DIV_D_W-1:0] : trial[wssc_pkg::DIV_D_W-1:0];
      low_q <= {low_q[wssc_pkg::DIV_Q_W-2:0], 1'b0};
      quo_q <= {quo_q[wssc_pkg::DIV_Q_W-2:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

endmodule

/* hdl/wssc_back.sv */
// ----------------------------------------------------------------------------
// wssc_back
// Math sequencer: reading normalization, polynomial correction, speed scaling,
// median of three, moving average and output scaling, one reading at a time.
// ----------------------------------------------------------------------------
module wssc_back #(
  parameter int unsigned N     = 32,
  parameter int unsigned SUM_W = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wssc_pkg::cfg_t               cfg_i,
  input  logic                         q_valid_i,
  input  logic [SUM_W:0]               q_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wssc_pkg::OUT_W-1:0]   speed_o,
  output logic                         reading_valid_o
);

  localparam bit          IS_POW2 = ((N & (N - 1)) == 0);
  localparam int unsigned LOG2_N  = $clog2(N);

  wssc_pkg::back_state_e state_q, state_d;
  wssc_pkg::div_req_t    div_req;
  wssc_pkg::div_rsp_t    div_rsp;

  // datapath registers
  logic [wssc_pkg::U_W-1:0]            u_q;
  logic signed [wssc_pkg::ACC_W-1:0]   acc_q;
  logic signed [wssc_pkg::PROD_W-1:0]  prod_q;
  logic [1:0]                          step_q;
  logic signed [31:0]                  num_q;
  logic [44:0]                         dvd_q;
  logic [wssc_pkg::SPEED_W-1:0]        speed_q, med_q;
  logic                                flag_q;
  logic [39:0]                         ema_p_q;
  logic [40:0]                         ema_s_q;
  logic [21:0]                         x_q;
  logic [44:0]                         r_q;

  // filter state and output register
  logic [wssc_pkg::SPEED_W-1:0]        hist_q [3];
  logic [1:0]                          slot_q;
  logic [wssc_pkg::SPEED_W-1:0]        ema_q;
  logic                                out_valid_q;
  logic [wssc_pkg::OUT_W-1:0]          out_speed_q;
  logic                                out_flag_q;

  // queue head unpacked
  logic [31:0]                         sum_ext;
  logic                                head_flag;
  logic [27:0]                         u_dvd;
  logic [wssc_pkg::U_W-1:0]            u_shift;

  assign sum_ext   = 32'(q_data_i[SUM_W-1:0]);
  assign head_flag = q_data_i[SUM_W];
  assign u_dvd     = {sum_ext[19:0], 8'b0};
  assign u_shift   = wssc_pkg::U_W'(u_dvd >> LOG2_N);

  // horner partial products
  logic [37:0]                         lo_prod;
  logic signed [18:0]                  acc_hi;
  logic signed [20:0]                  u_s;
  logic signed [39:0]                  hi_prod;

  assign lo_prod = acc_q[17:0] * u_q;
  assign acc_hi  = acc_q[36:18];
  assign u_s     = {1'b0, u_q};
  assign hi_prod = acc_hi * u_s;

  // voltage to speed numerator
  logic signed [31:0]                  v16_ext, v16_x1000, vmin_q16;
  logic [wssc_pkg::DIV_D_W-1:0]        span;

  assign v16_ext   = {{11{acc_q[36]}}, acc_q[36:16]};
  assign v16_x1000 = v16_ext * 32'sd1000;
  assign vmin_q16  = $signed({3'b0, cfg_i.volt_min, 16'b0});
  assign span      = {cfg_i.volt_max - cfg_i.volt_min, 8'b0};

  // median of three with the new speed in place
  logic [wssc_pkg::SPEED_W-1:0]        ha, hb, hc, mn_ab, mx_ab, mn_c, med;

  assign ha    = (slot_q == 2'd0) ? speed_q : hist_q[0];
  assign hb    = (slot_q == 2'd1) ? speed_q : hist_q[1];
  assign hc    = (slot_q == 2'd2) ? speed_q : hist_q[2];
  assign mn_ab = (ha < hb) ? ha : hb;
  assign mx_ab = (ha > hb) ? ha : hb;
  assign mn_c  = (mx_ab < hc) ? mx_ab : hc;
  assign med   = (mn_ab > mn_c) ? mn_ab : mn_c;

  // moving average weight of the old value
  logic [16:0]                         beta;
  assign beta = 17'h10000 - {1'b0, cfg_i.alpha};

  // output scaling to tenths of km/h
  logic [29:0]                         scaled;
  logic [15:0]                         tenths;
  logic [wssc_pkg::OUT_W-1:0]          tenths_sat;
  logic                                load_out;

  assign scaled     = 30'({ema_q, 5'b0}) + 30'({ema_q, 2'b0}) + 30'd12800;
  assign tenths     = r_q[44:29];
  assign tenths_sat = (tenths > 16'(wssc_pkg::OUT_MAX)) ? wssc_pkg::OUT_MAX
                                                       : tenths[wssc_pkg::OUT_W-1:0];
  assign load_out   = (state_q == wssc_pkg::BK_FINISH) && (!out_valid_q || out_ready_i);

  assign out_valid_o     = out_valid_q;
  assign speed_o         = out_speed_q;
  assign reading_valid_o = out_flag_q;

  wssc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer next state and divider requests
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    div_req = '0;
    case (state_q)
      wssc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          if (!head_flag) begin
            state_d = wssc_pkg::BK_MEDIAN;
          end else if (IS_POW2) begin
            state_d = wssc_pkg::BK_POLY_LO;
          end else begin
            div_req.start    = 1'b1;
            div_req.steps    = wssc_pkg::DIV_CNT_W'(wssc_pkg::U_W);
            div_req.rem_init = wssc_pkg::DIV_D_W'(sum_ext[19:12]);
            div_req.low_init = {sum_ext[11:0], 12'b0};
            div_req.divisor  = wssc_pkg::DIV_D_W'(N);
            state_d          = wssc_pkg::BK_UDIV;
          end
        end
      end
      wssc_pkg::BK_UDIV: begin
        if (div_rsp.done) state_d = wssc_pkg::BK_POLY_LO;
      end
      wssc_pkg::BK_POLY_LO:  state_d = wssc_pkg::BK_POLY_HI;
      wssc_pkg::BK_POLY_HI:  state_d = wssc_pkg::BK_POLY_ADD;
      wssc_pkg::BK_POLY_ADD: begin
        state_d = (step_q == 2'd3) ? wssc_pkg::BK_VOLT : wssc_pkg::BK_POLY_LO;
      end
      wssc_pkg::BK_VOLT: begin
        state_d = (cfg_i.volt_max > cfg_i.volt_min) ? wssc_pkg::BK_SPD_MUL
                                                    : wssc_pkg::BK_MEDIAN;
      end
      wssc_pkg::BK_SPD_MUL: begin
        state_d = (num_q > 32'sd0) ? wssc_pkg::BK_SPD_CHK : wssc_pkg::BK_MEDIAN;
      end
      wssc_pkg::BK_SPD_CHK: begin
        if (dvd_q[44:24] >= span) begin
          state_d = wssc_pkg::BK_MEDIAN;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = wssc_pkg::DIV_CNT_W'(wssc_pkg::DIV_Q_W);
          div_req.rem_init = dvd_q[44:24];
          div_req.low_init = dvd_q[23:0];
          div_req.divisor  = span;
          state_d          = wssc_pkg::BK_SPD_DIV;
        end
      end
      wssc_pkg::BK_SPD_DIV: begin
        if (div_rsp.done) state_d = wssc_pkg::BK_MEDIAN;
      end
      wssc_pkg::BK_MEDIAN:    state_d = wssc_pkg::BK_EMA_MUL;
      wssc_pkg::BK_EMA_MUL:   state_d = wssc_pkg::BK_EMA_MAC;
      wssc_pkg::BK_EMA_MAC:   state_d = wssc_pkg::BK_EMA_SET;
      wssc_pkg::BK_EMA_SET:   state_d = wssc_pkg::BK_OUT_SCALE;
      wssc_pkg::BK_OUT_SCALE: state_d = wssc_pkg::BK_OUT_MUL;
      wssc_pkg::BK_OUT_MUL:   state_d = wssc_pkg::BK_FINISH;
      wssc_pkg::BK_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = wssc_pkg::BK_IDLE;
      end
      default: state_d = wssc_pkg::BK_IDLE;
    endcase
  end

  // state, filter history and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wssc_pkg::BK_IDLE;
      hist_q[0]   <= '0;
      hist_q[1]   <= '0;
      hist_q[2]   <= '0;
      slot_q      <= 2'd0;
      ema_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wssc_pkg::BK_MEDIAN) begin
        hist_q[0] <= ha;
        hist_q[1] <= hb;
        hist_q[2] <= hc;
        slot_q    <= (slot_q >= 2'd2) ? 2'd0 : slot_q + 2'd1;
      end
      if (state_q == wssc_pkg::BK_EMA_SET) ema_q <= ema_s_q[39:16];
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      wssc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          flag_q  <= head_flag;
          speed_q <= '0;
          acc_q   <= wssc_pkg::POLY_D4;
          step_q  <= 2'd0;
          u_q     <= u_shift;
        end
      end
      wssc_pkg::BK_UDIV: begin
        if (div_rsp.done) u_q <= div_rsp.quotient[wssc_pkg::U_W-1:0];
      end
      wssc_pkg::BK_POLY_LO: prod_q <= $signed(wssc_pkg::PROD_W'(lo_prod));
      wssc_pkg::BK_POLY_HI: prod_q <= prod_q + $signed({hi_prod, 18'b0});
      wssc_pkg::BK_POLY_ADD: begin
        acc_q  <= $signed(prod_q[56:20]) + wssc_pkg::poly_coef(step_q);
        step_q <= step_q + 2'd1;
      end
      wssc_pkg::BK_VOLT:    num_q <= v16_x1000 - vmin_q16;
      wssc_pkg::BK_SPD_MUL: dvd_q <= num_q[30:0] * cfg_i.speed_max;
      wssc_pkg::BK_SPD_CHK: begin
        if (dvd_q[44:24] >= span) speed_q <= wssc_pkg::SPEED_SAT;
      end
      wssc_pkg::BK_SPD_DIV: begin
        if (div_rsp.done) speed_q <= div_rsp.quotient;
      end
      wssc_pkg::BK_MEDIAN:    med_q   <= med;
      wssc_pkg::BK_EMA_MUL:   ema_p_q <= cfg_i.alpha * med_q;
      wssc_pkg::BK_EMA_MAC:   ema_s_q <= 41'(ema_p_q) + beta * ema_q;
      wssc_pkg::BK_OUT_SCALE: x_q     <= scaled[29:8];
      wssc_pkg::BK_OUT_MUL:   r_q     <= x_q * wssc_pkg::RECIP_100;
      wssc_pkg::BK_FINISH: begin
        if (load_out) begin
          out_speed_q <= tenths_sat;
          out_flag_q  <= flag_q;
        end
      end
      default: ;
    endcase
  end

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("reading taken from an empty queue");

  a_ema_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wssc_pkg::BK_EMA_SET) |=> $stable(ema_q))
    else $error("average changed outside its update step");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == wssc_pkg::BK_UDIV || state_q == wssc_pkg::BK_SPD_DIV))
    else $error("divider finished while nothing waits for it");

endmodule

/* hdl/wind_speed_sensor_conditioner_unit.sv */
// ----------------------------------------------------------------------------
// wind_speed_sensor_conditioner_unit
// Samples are taken one per cycle, but the last sample of a group waits while
// the queue is full; each group of SAMPLES_PER_READING gives one result, after
// an extra normalizing division when the group size is not a power of two.
// The back end takes one reading at a time through its polynomial steps and
// the speed divider; a two-entry queue decouples intake.
// Reset clears the accumulator, median history, average and output valid.
// ----------------------------------------------------------------------------
module wind_speed_sensor_conditioner_unit #(
  parameter int unsigned SAMPLES_PER_READING = 32,
  parameter int unsigned ADC_BITS            = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ADC_BITS-1:0]           adc_sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wssc_pkg::OUT_W-1:0]    speed_tenths_kmh_o,
  output logic                          reading_valid_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wssc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned SUM_W = ADC_BITS + $clog2(SAMPLES_PER_READING);
  localparam int unsigned CNT_W = (SAMPLES_PER_READING > 1) ?
                                  $clog2(SAMPLES_PER_READING) : 1;

  wssc_pkg::cfg_t                cfg_q;
  logic [wssc_pkg::IDX_W-1:0]    reg_idx;
  logic                          push, pop, q_full, q_nonempty;
  logic [SUM_W:0]                push_data, pop_data;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[wssc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale <= wssc_pkg::FULL_SCALE_RST;
      cfg_q.volt_min   <= wssc_pkg::VOLT_MIN_RST;
      cfg_q.volt_max   <= wssc_pkg::VOLT_MAX_RST;
      cfg_q.speed_max  <= wssc_pkg::SPEED_MAX_RST;
      cfg_q.alpha      <= wssc_pkg::EMA_ALPHA_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        wssc_pkg::REG_FULL_SCALE: cfg_q.full_scale <= pwdata[wssc_pkg::FS_W-1:0];
        wssc_pkg::REG_VOLT_MIN:   cfg_q.volt_min   <= pwdata[wssc_pkg::MV_W-1:0];
        wssc_pkg::REG_VOLT_MAX:   cfg_q.volt_max   <= pwdata[wssc_pkg::MV_W-1:0];
        wssc_pkg::REG_SPEED_MAX:  cfg_q.speed_max  <= pwdata[wssc_pkg::SMAX_W-1:0];
        wssc_pkg::REG_EMA_ALPHA:  cfg_q.alpha      <= pwdata[wssc_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      wssc_pkg::REG_FULL_SCALE: prdata = 32'(cfg_q.full_scale);
      wssc_pkg::REG_VOLT_MIN:   prdata = 32'(cfg_q.volt_min);
      wssc_pkg::REG_VOLT_MAX:   prdata = 32'(cfg_q.volt_max);
      wssc_pkg::REG_SPEED_MAX:  prdata = 32'(cfg_q.speed_max);
      wssc_pkg::REG_EMA_ALPHA:  prdata = 32'(cfg_q.alpha);
      default:                  prdata = '0;
    endcase
  end

  wssc_front #(
    .N        (SAMPLES_PER_READING),
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  wssc_queue #(
    .WIDTH (SUM_W + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .nonempty_o  (q_nonempty)
  );

  wssc_back #(
    .N     (SAMPLES_PER_READING),
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_nonempty),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speed_o         (speed_tenths_kmh_o),
    .reading_valid_o (reading_valid_o)
  );

endmodule
